// ===== rtl/core/hblt_pkg.sv =====
// Package for the heartbeat liveness tracker: types, codes and reset constants.
`default_nettype none

package hblt_pkg;

  localparam int unsigned TIME_BITS_DEFAULT = 32;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned FRESH_W     = 64;
  localparam int unsigned IV_CFG_W    = 16;
  localparam int unsigned IV_W        = 17;
  localparam int unsigned OUT_TDATA_W = 88;

  localparam logic [IV_CFG_W-1:0] INTERVAL_MIN_RST = 16'd100;
  localparam logic [IV_CFG_W-1:0] INTERVAL_MAX_RST = 16'd1000;
  localparam logic [IV_CFG_W-1:0] PONG_TIMEOUT_RST = 16'd3000;
  localparam logic [FRESH_W-1:0]  FRESH_SEED_RST   = 64'd0;

  typedef enum logic [1:0] {
    OP_TICK         = 2'd0,
    OP_PONG         = 2'd1,
    OP_MSG_DOWN     = 2'd2,
    OP_SEND_TIMEOUT = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    LS_UNSURE = 2'd0,
    LS_UP     = 2'd1,
    LS_DOWN   = 2'd2
  } link_state_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INTERVAL_MIN = 2'd0,
    CFG_INTERVAL_MAX = 2'd1,
    CFG_PONG_TIMEOUT = 2'd2,
    CFG_FRESH_SEED   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               state_set;
    logic [IV_W-1:0]    current_interval;
    logic [1:0]         link_state;
    logic [FRESH_W-1:0] ping_value;
    logic               ping_sent;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/heartbeat_liveness_tracker_top.sv =====
// Top level of the heartbeat liveness tracker: stream ports, config port, core and result stage.
//
//   channel  direction  handshake                      payload
//   s_axis   in         s_axis_tvalid / s_axis_tready  tuser opcode, tdata pong_value
//   m_axis   out        m_axis_tvalid / m_axis_tready  tuser ping_sent, tdata result fields
//   cfg      in         cfg_we_i (no wait)             cfg_index_i, cfg_data_i
//
// One transfer per cycle while s_axis_tready is high; a result is registered before it leaves.
// Latency and rate are set by the single update pass between the state
// registers and the result register.
// Reset clears all state and loads the register reset values; no clearing pass.
// A stalled output holds up to two results; s_axis_tready drops only then.
`default_nettype none

module heartbeat_liveness_tracker_top #(
  parameter int unsigned TIME_BITS = hblt_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [hblt_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [hblt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [hblt_pkg::FRESH_W-1:0]        s_axis_tdata,  // [63:0] pong_value
  input  wire logic [1:0]                          s_axis_tuser,  // [1:0] opcode
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [63:0] ping_value, [65:64] link_state, [82:66] current_interval,
  // [83] state_set, [87:84] zero
  output logic [hblt_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic [0:0]                               m_axis_tuser   // [0] ping_sent
);

  localparam int unsigned PackW = hblt_pkg::FRESH_W + 2 + hblt_pkg::IV_W + 1;

  logic              accept;
  hblt_pkg::result_t core_result, out_result;

  assign accept = s_axis_tvalid && s_axis_tready;

  hblt_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .opcode_i     (s_axis_tuser),
    .pong_value_i (s_axis_tdata),
    .result_o     (core_result)
  );

  hblt_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .result_i (core_result),
    .ready_o  (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {{(hblt_pkg::OUT_TDATA_W - PackW){1'b0}},
                         out_result.state_set,
                         out_result.current_interval,
                         out_result.link_state,
                         out_result.ping_value};
  assign m_axis_tuser = out_result.ping_sent;

endmodule

`default_nettype wire

// ===== rtl/core/hblt_core.sv =====
// Liveness state registers and the single-pass update for one transfer.
`default_nettype none

module hblt_core #(
  parameter int unsigned TIME_BITS = hblt_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [hblt_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [hblt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                               accept_i,
  input  wire logic [1:0]                         opcode_i,
  input  wire logic [hblt_pkg::FRESH_W-1:0]       pong_value_i,
  output hblt_pkg::result_t                       result_o
);

  logic [hblt_pkg::IV_CFG_W-1:0] imin_q, imax_q, timeout_q;
  logic [hblt_pkg::IV_W-1:0]     interval_q, interval_d, interval_dbl;
  logic [TIME_BITS-1:0]          tsp_q, tsp_d, tsp_inc;
  logic [TIME_BITS-1:0]          tpo_q, tpo_d, tpo_inc;
  logic [hblt_pkg::FRESH_W-1:0]  fresh_q, fresh_d;
  hblt_pkg::link_state_e         state_q, state_d;
  logic                          due, sent, set;

  always_comb begin
    state_d      = state_q;
    interval_d   = interval_q;
    tsp_d        = tsp_q;
    tpo_d        = tpo_q;
    fresh_d      = fresh_q;
    sent         = 1'b0;
    set          = 1'b0;
    interval_dbl = {interval_q[hblt_pkg::IV_W-2:0], 1'b0};
    tsp_inc      = (tsp_q == '1) ? tsp_q : tsp_q + 1'b1;
    tpo_inc      = (tpo_q == '1) ? tpo_q : tpo_q + 1'b1;
    due          = tsp_inc > TIME_BITS'(interval_q);
    case (hblt_pkg::opcode_e'(opcode_i))
      hblt_pkg::OP_TICK: begin
        tsp_d = tsp_inc;
        tpo_d = tpo_inc;
        if (due && (state_q == hblt_pkg::LS_UNSURE || state_q == hblt_pkg::LS_UP)) begin
          tsp_d   = '0;
          fresh_d = fresh_q + 1'b1;
          sent    = 1'b1;
          if (state_q == hblt_pkg::LS_UNSURE) begin
            interval_d = interval_dbl;
            if (interval_dbl > {1'b0, imax_q}) begin
              state_d = hblt_pkg::LS_DOWN;
              set     = 1'b1;
            end
          end else if (tpo_inc > TIME_BITS'(timeout_q)) begin
            state_d = hblt_pkg::LS_DOWN;
            set     = 1'b1;
          end
        end
      end
      hblt_pkg::OP_PONG: begin
        if (pong_value_i == fresh_q) begin
          if (state_q == hblt_pkg::LS_UNSURE) begin
            state_d    = hblt_pkg::LS_UP;
            interval_d = {1'b0, imax_q};
            set        = 1'b1;
            tpo_d      = '0;
          end else if (state_q == hblt_pkg::LS_UP) begin
            tpo_d = '0;
          end
        end
      end
      hblt_pkg::OP_MSG_DOWN, hblt_pkg::OP_SEND_TIMEOUT: begin
        state_d    = hblt_pkg::LS_UNSURE;
        interval_d = {1'b0, imin_q};
        tsp_d      = '1;
        set        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.ping_sent        = sent;
    result_o.ping_value       = sent ? fresh_d : '0;
    result_o.link_state       = state_d;
    result_o.current_interval = interval_d;
    result_o.state_set        = set;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imin_q    <= hblt_pkg::INTERVAL_MIN_RST;
      imax_q    <= hblt_pkg::INTERVAL_MAX_RST;
      timeout_q <= hblt_pkg::PONG_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (hblt_pkg::cfg_reg_e'(cfg_index_i))
        hblt_pkg::CFG_INTERVAL_MIN: imin_q    <= cfg_data_i[hblt_pkg::IV_CFG_W-1:0];
        hblt_pkg::CFG_INTERVAL_MAX: imax_q    <= cfg_data_i[hblt_pkg::IV_CFG_W-1:0];
        hblt_pkg::CFG_PONG_TIMEOUT: timeout_q <= cfg_data_i[hblt_pkg::IV_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= hblt_pkg::FRESH_SEED_RST;
    end else if (cfg_we_i && cfg_index_i == hblt_pkg::CFG_FRESH_SEED) begin
      fresh_q <= cfg_data_i;
    end else if (accept_i) begin
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hblt_pkg::LS_UNSURE;
      interval_q <= {1'b0, hblt_pkg::INTERVAL_MIN_RST};
      tsp_q      <= '1;
      tpo_q      <= '1;
    end else if (accept_i) begin
      state_q    <= state_d;
      interval_q <= interval_d;
      tsp_q      <= tsp_d;
      tpo_q      <= tpo_d;
    end
  end

  a_ping_clears_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && sent |=> tsp_q == '0)
    else $error("ping sent but since-ping counter not cleared");

  a_event_to_unsure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (opcode_i == hblt_pkg::OP_MSG_DOWN || opcode_i == hblt_pkg::OP_SEND_TIMEOUT)
    |=> state_q == hblt_pkg::LS_UNSURE && tsp_q == '1)
    else $error("message or timeout did not re-enter unsure");

  a_down_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hblt_pkg::LS_DOWN &&
    !(accept_i && (opcode_i == hblt_pkg::OP_MSG_DOWN || opcode_i == hblt_pkg::OP_SEND_TIMEOUT))
    |=> state_q == hblt_pkg::LS_DOWN)
    else $error("down state left without message or timeout");

  a_fresh_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i && !(accept_i && sent) |=> $stable(fresh_q))
    else $error("freshness count moved without a ping");

endmodule

`default_nettype wire

// ===== rtl/core/hblt_out_stage.sv =====
// Result register with a skid entry; the input waits only while both entries are full.
`default_nettype none

module hblt_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire hblt_pkg::result_t result_i,
  output logic               ready_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output hblt_pkg::result_t  result_o
);

  logic              out_valid_q, skid_valid_q;
  hblt_pkg::result_t out_q, skid_q;
  logic              pop;

  assign pop      = out_valid_q && ready_i;
  assign ready_o  = !skid_valid_q;
  assign valid_o  = out_valid_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= result_i;
      end else begin
        out_q <= result_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/heartbeat_liveness_tracker_top_tb.sv =====
// Testbench for the heartbeat liveness tracker: directed table plus random phases vs. predictor.
`timescale 1ns / 100ps

module heartbeat_liveness_tracker_top_tb;
  import hblt_pkg::*;

  localparam int unsigned TICK_W = TIME_BITS_DEFAULT;

  typedef enum {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    cfg_reg_e           reg_idx;
    opcode_e            op;
    logic [FRESH_W-1:0] data;
    bit                 typed;
    result_t            want;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [FRESH_W-1:0]     s_axis_tdata;   // [63:0] pong_value
  logic [1:0]             s_axis_tuser;   // [1:0] opcode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [63:0] ping_value, [65:64] link_state, [82:66] current_interval, [83] state_set
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;   // [0] ping_sent

  link_state_e        lk_state;
  logic [IV_W-1:0]    lk_interval;
  logic [TICK_W-1:0]  lk_since_ping;
  logic [TICK_W-1:0]  lk_since_pong;
  logic [FRESH_W-1:0] lk_fresh;
  logic [IV_CFG_W-1:0] cf_iv_min;
  logic [IV_CFG_W-1:0] cf_iv_max;
  logic [IV_CFG_W-1:0] cf_pong_to;

  result_t     pending_results[$];
  int unsigned bad_cnt;
  bit          src_calm;

  heartbeat_liveness_tracker_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic result_t want(bit sent, logic [FRESH_W-1:0] value, link_state_e ls,
                                   logic [IV_W-1:0] iv, bit set);
    result_t r;
    r.ping_sent        = sent;
    r.ping_value       = value;
    r.link_state       = ls;
    r.current_interval = iv;
    r.state_set        = set;
    return r;
  endfunction

  function automatic plan_row_t item_row(opcode_e op, logic [FRESH_W-1:0] data, bit typed,
                                         result_t w);
    plan_row_t row;
    row.kind    = ROW_ITEM;
    row.reg_idx = CFG_INTERVAL_MIN;
    row.op      = op;
    row.data    = data;
    row.typed   = typed;
    row.want    = w;
    return row;
  endfunction

  function automatic plan_row_t reg_row(cfg_reg_e idx, logic [FRESH_W-1:0] data);
    plan_row_t row;
    row         = item_row(OP_TICK, data, 1'b0, '0);
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    return row;
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic result_t advance_link(opcode_e op, logic [FRESH_W-1:0] pong);
    result_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        lk_since_ping = (lk_since_ping == '1) ? lk_since_ping : lk_since_ping + 1'b1;
        lk_since_pong = (lk_since_pong == '1) ? lk_since_pong : lk_since_pong + 1'b1;
        if (lk_state != LS_DOWN && lk_since_ping > lk_interval) begin
          lk_since_ping = '0;
          lk_fresh      = lk_fresh + 1'b1;
          r.ping_sent   = 1'b1;
          r.ping_value  = lk_fresh;
          if (lk_state == LS_UNSURE) begin
            lk_interval = {lk_interval[IV_W-2:0], 1'b0};
            if (lk_interval > cf_iv_max) begin
              lk_state    = LS_DOWN;
              r.state_set = 1'b1;
            end
          end else if (lk_since_pong > cf_pong_to) begin
            lk_state    = LS_DOWN;
            r.state_set = 1'b1;
          end
        end
      end
      OP_PONG: begin
        if (pong == lk_fresh) begin
          if (lk_state == LS_UNSURE) begin
            lk_state    = LS_UP;
            lk_interval = {1'b0, cf_iv_max};
            r.state_set = 1'b1;
          end
          if (lk_state == LS_UP) lk_since_pong = '0;
        end
      end
      default: begin
        lk_state      = LS_UNSURE;
        lk_interval   = {1'b0, cf_iv_min};
        lk_since_ping = '1;
        r.state_set   = 1'b1;
      end
    endcase
    r.link_state       = lk_state;
    r.current_interval = lk_interval;
    return r;
  endfunction

  task automatic push_item(opcode_e op, logic [FRESH_W-1:0] data, bit typed, result_t w);
    int unsigned gap;
    result_t     guess;
    gap = pick_gap(src_calm);
    cfg_we_i <= 1'b0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    guess = advance_link(op, data);
    pending_results.push_back(typed ? w : guess);
  endtask

  // Drain first: registers change only while nothing is in flight.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_INTERVAL_MIN: cf_iv_min  = data[IV_CFG_W-1:0];
      CFG_INTERVAL_MAX: cf_iv_max  = data[IV_CFG_W-1:0];
      CFG_PONG_TIMEOUT: cf_pong_to = data[IV_CFG_W-1:0];
      CFG_FRESH_SEED:   lk_fresh   = data;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    plan_row_t           plan[$];
    logic [IV_CFG_W-1:0] iv_min;
    logic [IV_CFG_W-1:0] iv_max;
    logic [IV_CFG_W-1:0] p_to;
    logic [FRESH_W-1:0]  seed;
    logic [FRESH_W-1:0]  junk;
    int unsigned         pong_pct;
    int unsigned         pick;
    int unsigned         guard;
    bad_cnt       = 0;
    src_calm      = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_INTERVAL_MIN;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_TICK;
    cf_iv_min     = INTERVAL_MIN_RST;
    cf_iv_max     = INTERVAL_MAX_RST;
    cf_pong_to    = PONG_TIMEOUT_RST;
    lk_state      = LS_UNSURE;
    lk_interval   = {1'b0, INTERVAL_MIN_RST};
    lk_since_ping = '1;
    lk_since_pong = '1;
    lk_fresh      = FRESH_SEED_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(item_row(OP_TICK, '0, 1, want(1, 1, LS_UNSURE, 200, 0)));
    plan.push_back(item_row(OP_PONG, '0, 1, want(0, 0, LS_UNSURE, 200, 0)));
    plan.push_back(item_row(OP_PONG, 1, 1, want(0, 0, LS_UP, 1000, 1)));
    plan.push_back(item_row(OP_PONG, 1, 1, want(0, 0, LS_UP, 1000, 0)));
    plan.push_back(item_row(OP_TICK, '1, 1, want(0, 0, LS_UP, 1000, 0)));
    plan.push_back(item_row(OP_MSG_DOWN, '0, 1, want(0, 0, LS_UNSURE, 100, 1)));
    plan.push_back(item_row(OP_SEND_TIMEOUT, '1, 1, want(0, 0, LS_UNSURE, 100, 1)));
    plan.push_back(item_row(OP_TICK, '0, 1, want(1, 2, LS_UNSURE, 200, 0)));
    plan.push_back(item_row(OP_PONG, '1, 0, '0));
    plan.push_back(reg_row(CFG_INTERVAL_MAX, 1));
    plan.push_back(item_row(OP_SEND_TIMEOUT, '0, 1, want(0, 0, LS_UNSURE, 100, 1)));
    plan.push_back(item_row(OP_TICK, '0, 1, want(1, 3, LS_DOWN, 200, 1)));
    plan.push_back(item_row(OP_TICK, '0, 1, want(0, 0, LS_DOWN, 200, 0)));
    plan.push_back(item_row(OP_PONG, 3, 1, want(0, 0, LS_DOWN, 200, 0)));
    plan.push_back(item_row(OP_MSG_DOWN, '0, 1, want(0, 0, LS_UNSURE, 100, 1)));
    plan.push_back(reg_row(CFG_INTERVAL_MIN, 16'hFFFF));
    plan.push_back(reg_row(CFG_INTERVAL_MAX, 16'hFFFF));
    plan.push_back(item_row(OP_SEND_TIMEOUT, '0, 1, want(0, 0, LS_UNSURE, 65535, 1)));
    plan.push_back(item_row(OP_TICK, '0, 1, want(1, 4, LS_DOWN, 131070, 1)));
    plan.push_back(reg_row(CFG_FRESH_SEED, '1));
    plan.push_back(reg_row(CFG_INTERVAL_MIN, 0));
    plan.push_back(reg_row(CFG_INTERVAL_MAX, 0));
    plan.push_back(reg_row(CFG_PONG_TIMEOUT, 0));
    plan.push_back(item_row(OP_MSG_DOWN, '0, 1, want(0, 0, LS_UNSURE, 0, 1)));
    plan.push_back(item_row(OP_TICK, '0, 1, want(1, 0, LS_UNSURE, 0, 0)));
    plan.push_back(item_row(OP_TICK, '0, 1, want(1, 1, LS_UNSURE, 0, 0)));
    plan.push_back(item_row(OP_PONG, 1, 1, want(0, 0, LS_UP, 0, 1)));
    plan.push_back(item_row(OP_TICK, '0, 1, want(1, 2, LS_DOWN, 0, 1)));
    plan.push_back(reg_row(CFG_PONG_TIMEOUT, 16'hFFFF));
    plan.push_back(reg_row(CFG_INTERVAL_MAX, 3));
    plan.push_back(item_row(OP_SEND_TIMEOUT, '0, 0, '0));
    plan.push_back(item_row(OP_TICK, '0, 0, '0));
    plan.push_back(item_row(OP_PONG, 3, 0, '0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        write_reg(plan[i].reg_idx, plan[i].data);
      end else begin
        push_item(plan[i].op, plan[i].data, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      iv_min = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
      iv_max = (ph == 5) ? 16'hFFFF : 16'($urandom_range(1, 24));
      p_to   = (ph == 3) ? 16'hFFFF : 16'($urandom_range(0, 24));
      seed   = ($urandom_range(0, 2) == 0) ? ~64'($urandom_range(0, 4)) : {$urandom, $urandom};
      write_reg(CFG_INTERVAL_MIN, {$urandom, 16'($urandom), iv_min});
      write_reg(CFG_INTERVAL_MAX, {$urandom, 16'($urandom), iv_max});
      write_reg(CFG_PONG_TIMEOUT, {$urandom, 16'($urandom), p_to});
      write_reg(CFG_FRESH_SEED, seed);
      src_calm = (ph == 1) || ($urandom_range(0, 4) == 0);
      pong_pct = $urandom_range(5, 40);
      for (int n = 0; n < 170; n++) begin
        pick = $urandom_range(0, 99);
        junk = {$urandom, $urandom};
        if (pick < pong_pct) push_item(OP_PONG, lk_fresh, 0, '0);
        else if (pick < pong_pct + 4) push_item(OP_PONG, lk_fresh - 1'b1, 0, '0);
        else if (pick < pong_pct + 8) push_item(OP_PONG, junk, 0, '0);
        else if (pick < pong_pct + 11) push_item(OP_MSG_DOWN, junk, 0, '0);
        else if (pick < pong_pct + 14) push_item(OP_SEND_TIMEOUT, junk, 0, '0);
        else push_item(OP_TICK, junk, 0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_results.size() != 0) begin
      bad_cnt++;
      $display("%0d results never arrived", pending_results.size());
    end
    repeat (20) @(posedge clk_i);
    if (bad_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : result_check
    result_t     got;
    result_t     w;
    int unsigned seen;
    int unsigned sink_wait;
    int unsigned cyc;
    bit          sink_calm;
    seen      = 0;
    sink_wait = 0;
    cyc       = 0;
    sink_calm = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[83:0], m_axis_tuser[0]};
        seen++;
        if (pending_results.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10) $display("unexpected transfer: %h", got);
        end else begin
          w = pending_results.pop_front();
          if (got.ping_sent != w.ping_sent || got.ping_value != w.ping_value ||
              got.link_state != w.link_state || got.current_interval != w.current_interval ||
              got.state_set != w.state_set) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("mismatch #%0d exp/act: sent %0b/%0b value %h/%h state %0d/%0d",
                       seen, w.ping_sent, got.ping_sent, w.ping_value, got.ping_value,
                       w.link_state, got.link_state);
              $display("  interval %0d/%0d set %0b/%0b", w.current_interval,
                       got.current_interval, w.state_set, got.state_set);
            end
          end
        end
        // hold off long enough to fill the output and stall the input
        if (seen == 300 || seen == 900) sink_wait = 80;
      end
      if (cyc % 200 == 0) sink_calm = ($urandom_range(0, 2) == 0);
      if (sink_wait > 0) begin
        m_axis_tready <= 1'b0;
        sink_wait--;
      end else begin
        m_axis_tready <= 1'b1;
        sink_wait = pick_gap(sink_calm);
      end
    end
  end

endmodule

// ===== heartbeat_liveness_tracker_top.f =====
rtl/core/hblt_pkg.sv
rtl/core/hblt_core.sv
rtl/core/hblt_out_stage.sv
rtl/core/heartbeat_liveness_tracker_top.sv
tb/heartbeat_liveness_tracker_top_tb.sv
